FILE: rtl/tcb_pkg.sv
`default_nettype none
package tcb_pkg;

  localparam int ADDR_W   = 16;
  localparam int ROW_BITS = 6;
  localparam int CNT_W    = 12;
  localparam int CELL_W   = 24;

  localparam logic [ADDR_W-1:0] ROW_CELLS  = 16'h0040;
  localparam logic [ADDR_W-1:0] ROW_MASK   = 16'hffc0;
  localparam logic [ADDR_W-1:0] WIN_CELLS  = 16'h0800;
  localparam logic [ADDR_W-1:0] SCROLL_OFF = 16'h07c0;
  localparam logic [4:0]        BAR_MAX    = 5'd31;
  localparam logic [CNT_W-1:0]  WIN_CNT    = 12'd2048;
  localparam logic [CNT_W-1:0]  ROW_CNT    = 12'd64;

  localparam logic [7:0] RST_FG    = 8'h26;
  localparam logic [7:0] RST_BG    = 8'h22;
  localparam logic [6:0] RST_BLANK = 7'd32;
  localparam logic [7:0] RST_BLINK = 8'd32;
  localparam logic [4:0] RST_BAR   = 5'd8;

  typedef enum logic [2:0] {
    REG_FG    = 3'd0,
    REG_BG    = 3'd1,
    REG_BLANK = 3'd2,
    REG_BLINK = 3'd3,
    REG_BAR   = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    OP_PUT   = 4'd0,
    OP_NL    = 4'd1,
    OP_LEFT  = 4'd2,
    OP_RIGHT = 4'd3,
    OP_UP    = 4'd4,
    OP_DOWN  = 4'd5,
    OP_BS    = 4'd6,
    OP_INS   = 4'd7,
    OP_CLEAR = 4'd8,
    OP_BAR   = 4'd9,
    OP_TICK  = 4'd10,
    OP_READ  = 4'd11
  } op_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_OFF_RD, S_OFF_WR, S_EXEC, S_SCR, S_FILL, S_COPY_RD,
    S_COPY_WR, S_ON_RD, S_ON_WAIT, S_TOG, S_TICK_RD, S_TICK_WR, S_RD, S_OUT
  } state_t;

endpackage
`default_nettype wire

FILE: rtl/tcb_ram.sv
`default_nettype none
module tcb_ram #(
  parameter int WIDTH = 24,
  parameter int AW    = 16
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/text_console_buffer_engine.sv
// Text console scrollback engine: 64K cells of char/fg/bg in one single-port-read
// memory, 64-cell rows, 32-row window. After reset the block sweeps every cell to the
// blank value, one cell a cycle, before s_tready first rises. Each word then runs
// through a read-modify-write sequencer on that memory. Words put through clear first
// restore the saved reverse bit at the old cursor, then execute: put, newline, right
// and down blank a 64-cell row when the window scrolls; backspace and insert shift up
// to 63 cells and blank one; clear blanks a 2048-cell window; then the new cursor cell
// is read back. Unused codes skip the memory, read fetches one cell, tick may flip the
// cursor's reverse bit, and toggle restores only when it moves the cursor. The memory
// port, one access of each kind per cycle, paces the sequencer; a result waiting for
// m_tready stalls it. A finished result waits in the output register while the next word is accepted.
`default_nettype none
module text_console_buffer_engine
  import tcb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // op[3:0], char_code[10:4], read_offset[21:11]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [63:0] m_tdata,   // cursor_addr[15:0], window_base[31:16],
                                      // read_char[39:32], read_fg[47:40],
                                      // read_bg[55:48], blinked[56]
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [7:0]  cfg_data
);

  state_t state, state_next;

  logic [7:0] fg_color, bg_color, blink_period;
  logic [6:0] blank_code;
  logic [4:0] bar_rows;

  logic [ADDR_W-1:0] cur, cur_next, base, base_next, ptr, ptr_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic              dir, dir_next;
  logic              saved_rev, saved_rev_next;
  logic [7:0]        blink_cnt, blink_cnt_next;
  logic              bar_active, bar_active_next;
  logic [3:0]        op_r;
  logic [6:0]        code_r;
  logic [10:0]       roff_r;
  logic [7:0]        rc, rc_next, rf, rf_next, rb, rb_next;
  logic              bl, bl_next;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  logic [4:0]        bar_r;
  logic [10:0]       lim_on, lim;
  logic [ADDR_W-1:0] back_step, back_n, back_off, fwd_off;
  logic              back_ok;
  logic [CELL_W-1:0] blank_cell;

  tcb_ram #(.WIDTH(CELL_W), .AW(ADDR_W)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign s_tready   = (state == S_IDLE);
  assign blank_cell = {1'b0, blank_code, fg_color, bg_color};
  assign bar_r      = (bar_rows > BAR_MAX) ? BAR_MAX : bar_rows;
  assign lim_on     = {bar_r, {ROW_BITS{1'b0}}};
  assign lim        = bar_active ? lim_on : 11'd0;
  assign back_step  = (op_r == OP_UP) ? ROW_CELLS : 16'd1;
  assign back_n     = cur - back_step;
  assign back_off   = back_n - base;
  assign back_ok    = (back_off >= {5'd0, lim}) && (back_off < WIN_CELLS);
  assign fwd_off    = cur - base;

  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color     <= RST_FG;
      bg_color     <= RST_BG;
      blank_code   <= RST_BLANK;
      blink_period <= RST_BLINK;
      bar_rows     <= RST_BAR;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_FG:    fg_color     <= cfg_data;
        REG_BG:    bg_color     <= cfg_data;
        REG_BLANK: blank_code   <= cfg_data[6:0];
        REG_BLINK: blink_period <= cfg_data;
        REG_BAR:   bar_rows     <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLR:     if (ptr == {ADDR_W{1'b1}}) state_next = S_IDLE;
      S_IDLE: begin
        if (s_tvalid) begin
          if (s_tdata[3:0] <= OP_CLEAR) state_next = S_OFF_RD;
          else if (s_tdata[3:0] == OP_BAR) state_next = S_TOG;
          else if (s_tdata[3:0] == OP_TICK)
            state_next = (blink_cnt == 8'd0) ? S_TICK_RD : S_OUT;
          else if (s_tdata[3:0] == OP_READ) state_next = S_RD;
          else state_next = S_OUT;
        end
      end
      S_OFF_RD:  state_next = S_OFF_WR;
      S_OFF_WR:  state_next = S_EXEC;
      S_EXEC: begin
        case (op_r)
          OP_PUT, OP_NL, OP_RIGHT, OP_DOWN: state_next = S_SCR;
          OP_BS: begin
            if (!back_ok) state_next = S_ON_RD;
            else if (back_n[ROW_BITS-1:0] == {ROW_BITS{1'b1}}) state_next = S_FILL;
            else state_next = S_COPY_RD;
          end
          OP_INS: state_next = (cur[ROW_BITS-1:0] == {ROW_BITS{1'b1}}) ? S_FILL : S_COPY_RD;
          OP_CLEAR: state_next = S_FILL;
          default: state_next = S_ON_RD;
        endcase
      end
      S_SCR:     state_next = (fwd_off >= WIN_CELLS) ? S_FILL : S_ON_RD;
      S_FILL:    if (cnt == 12'd1) state_next = S_ON_RD;
      S_COPY_RD: state_next = S_COPY_WR;
      S_COPY_WR: state_next = (cnt == 12'd1) ? S_FILL : S_COPY_RD;
      S_ON_RD:   state_next = S_ON_WAIT;
      S_ON_WAIT: state_next = S_OUT;
      S_TOG: begin
        if (bar_active) state_next = S_OUT;
        else if (fwd_off < {5'd0, lim_on}) state_next = S_OFF_RD;
        else state_next = S_OUT;
      end
      S_TICK_RD: state_next = S_TICK_WR;
      S_TICK_WR: state_next = S_OUT;
      S_RD:      state_next = S_ON_WAIT;
      S_OUT:     if (!m_tvalid || m_tready) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cur_next        = cur;
    base_next       = base;
    ptr_next        = ptr;
    cnt_next        = cnt;
    dir_next        = dir;
    saved_rev_next  = saved_rev;
    blink_cnt_next  = blink_cnt;
    bar_active_next = bar_active;
    rc_next         = rc;
    rf_next         = rf;
    rb_next         = rb;
    bl_next         = bl;
    ram_we          = 1'b0;
    ram_waddr       = cur;
    ram_wdata       = ram_rdata;
    ram_raddr       = cur;
    case (state)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr;
        ram_wdata = {1'b0, RST_BLANK, RST_FG, RST_BG};
        ptr_next  = ptr + 16'd1;
      end
      S_IDLE: begin
        rc_next = 8'd0;
        rf_next = 8'd0;
        rb_next = 8'd0;
        bl_next = 1'b0;
        if (s_tvalid && s_tdata[3:0] == OP_TICK && blink_cnt != 8'd0)
          blink_cnt_next = blink_cnt - 8'd1;
      end
      S_OFF_WR: begin
        ram_we    = 1'b1;
        ram_wdata = {saved_rev, ram_rdata[CELL_W-2:0]};
      end
      S_EXEC: begin
        case (op_r)
          OP_PUT: begin
            ram_we    = 1'b1;
            ram_wdata = {1'b0, code_r, fg_color, bg_color};
            cur_next  = cur + 16'd1;
          end
          OP_NL:    cur_next = (cur + ROW_CELLS) & ROW_MASK;
          OP_RIGHT: cur_next = cur + 16'd1;
          OP_DOWN:  cur_next = cur + ROW_CELLS;
          OP_LEFT, OP_UP: if (back_ok) cur_next = back_n;
          OP_BS: begin
            if (back_ok) begin
              cur_next = back_n;
              ptr_next = back_n;
              dir_next = 1'b1;
              cnt_next = (back_n[ROW_BITS-1:0] == {ROW_BITS{1'b1}}) ? 12'd1 :
                         {{(CNT_W-ROW_BITS){1'b0}}, ~back_n[ROW_BITS-1:0]};
            end
          end
          OP_INS: begin
            ptr_next = cur | ~ROW_MASK;
            dir_next = 1'b0;
            cnt_next = (cur[ROW_BITS-1:0] == {ROW_BITS{1'b1}}) ? 12'd1 :
                       {{(CNT_W-ROW_BITS){1'b0}}, ~cur[ROW_BITS-1:0]};
          end
          OP_CLEAR: begin
            base_next = base + WIN_CELLS;
            ptr_next  = base + WIN_CELLS;
            cnt_next  = WIN_CNT;
            cur_next  = base + WIN_CELLS + {5'd0, lim};
          end
          OP_BAR:   cur_next = base + {5'd0, lim};
          default: ;
        endcase
      end
      S_SCR: begin
        if (fwd_off >= WIN_CELLS) begin
          base_next = (cur & ROW_MASK) - SCROLL_OFF;
          ptr_next  = cur & ROW_MASK;
          cnt_next  = ROW_CNT;
        end
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = ptr;
        ram_wdata = blank_cell;
        ptr_next  = ptr + 16'd1;
        cnt_next  = cnt - 12'd1;
      end
      S_COPY_RD: ram_raddr = dir ? ptr + 16'd1 : ptr - 16'd1;
      S_COPY_WR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr;
        ram_wdata = ram_rdata;
        ptr_next  = dir ? ptr + 16'd1 : ptr - 16'd1;
        cnt_next  = (cnt == 12'd1) ? 12'd1 : cnt - 12'd1;
      end
      S_ON_WAIT: begin
        if (op_r == OP_READ) begin
          rc_next = ram_rdata[23:16];
          rf_next = ram_rdata[15:8];
          rb_next = ram_rdata[7:0];
        end else begin
          saved_rev_next = ram_rdata[CELL_W-1];
          blink_cnt_next = 8'd0;
        end
      end
      S_TOG: begin
        bar_active_next = ~bar_active;
      end
      S_TICK_WR: begin
        ram_we         = 1'b1;
        ram_wdata      = ram_rdata ^ {1'b1, {(CELL_W-1){1'b0}}};
        blink_cnt_next = blink_period - 8'd1;
        bl_next        = 1'b1;
      end
      S_RD: ram_raddr = base + {5'd0, roff_r};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      cur        <= {5'd0, RST_BAR + 5'd1, {ROW_BITS{1'b0}}};
      base       <= '0;
      ptr        <= '0;
      cnt        <= '0;
      dir        <= 1'b0;
      saved_rev  <= 1'b0;
      blink_cnt  <= 8'd0;
      bar_active <= 1'b1;
      m_tvalid   <= 1'b0;
    end else begin
      state      <= state_next;
      cur        <= cur_next;
      base       <= base_next;
      ptr        <= ptr_next;
      cnt        <= cnt_next;
      dir        <= dir_next;
      saved_rev  <= saved_rev_next;
      blink_cnt  <= blink_cnt_next;
      bar_active <= bar_active_next;
      if (state == S_OUT && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    rc <= rc_next;
    rf <= rf_next;
    rb <= rb_next;
    bl <= bl_next;
    if (state == S_IDLE && s_tvalid) begin
      op_r   <= s_tdata[3:0];
      code_r <= s_tdata[10:4];
      roff_r <= s_tdata[21:11];
    end
    if (state == S_OUT && (!m_tvalid || m_tready))
      m_tdata <= {7'd0, bl, rb, rf, rc, base, cur};
  end

endmodule
`default_nettype wire

FILE: sim/tb_top.sv
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tcb_pkg::*;

  localparam int LIMIT = 16000000;

  typedef struct packed {
    logic [15:0] cursor;
    logic [15:0] base;
    logic [7:0]  rchar;
    logic [7:0]  rfg;
    logic [7:0]  rbg;
    logic        blinked;
  } console_view_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;  // op[3:0], char_code[10:4], read_offset[21:11]
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [63:0] m_tdata;       // cursor_addr, window_base, read_char, read_fg, read_bg, blinked
  logic        cfg_we = 0;
  logic [2:0]  cfg_addr = '0;
  logic [7:0]  cfg_data = '0;

  text_console_buffer_engine DUT (.*);

  // console model state
  logic [7:0]  chr_mem [65536];
  logic [7:0]  fgc_mem [65536];
  logic [7:0]  bgc_mem [65536];
  logic [15:0] cur, base;
  logic        rev_saved, bar_on;
  logic [7:0]  blink_cnt;
  logic [7:0]  fg_col, bg_col, blink_per;
  logic [6:0]  blank_chr;
  logic [4:0]  bar_rows;

  console_view_t expected_views[$];
  int errors = 0;
  int cycles = 0;
  int src_idle = 0, dst_idle = 0;

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [15:0] bar_limit();
    logic [15:0] r;
    r = (bar_rows > BAR_MAX) ? 16'(BAR_MAX) : 16'(bar_rows);
    return bar_on ? r * ROW_CELLS : 16'd0;
  endfunction

  function automatic void blank_at(logic [15:0] a);
    chr_mem[a] = {1'b0, blank_chr};
    fgc_mem[a] = fg_col;
    bgc_mem[a] = bg_col;
  endfunction

  function automatic void copy_at(logic [15:0] d, logic [15:0] s);
    chr_mem[d] = chr_mem[s];
    fgc_mem[d] = fgc_mem[s];
    bgc_mem[d] = bgc_mem[s];
  endfunction

  function automatic void scroll_check();
    logic [15:0] rs;
    if (16'(cur - base) < WIN_CELLS) return;
    rs = cur & ROW_MASK;
    base = rs - SCROLL_OFF;
    for (int i = 0; i < 64; i++) blank_at(rs + 16'(i));
  endfunction

  function automatic bit step_back(logic [15:0] stp);
    logic [15:0] n, off;
    n = cur - stp;
    off = n - base;
    if (off < bar_limit() || off >= WIN_CELLS) return 0;
    cur = n;
    return 1;
  endfunction

  function automatic void restore_cursor();
    chr_mem[cur][7] = rev_saved;
  endfunction

  function automatic void latch_cursor();
    rev_saved = chr_mem[cur][7];
    blink_cnt = 0;
  endfunction

  function automatic void console_reset();
    fg_col = RST_FG; bg_col = RST_BG; blank_chr = RST_BLANK;
    blink_per = RST_BLINK; bar_rows = RST_BAR;
    for (int i = 0; i < 65536; i++) blank_at(16'(i));
    cur = (16'(bar_rows) + 16'd1) * ROW_CELLS;
    base = 0; rev_saved = 0; blink_cnt = 0; bar_on = 1;
  endfunction

  function automatic console_view_t console_apply(logic [3:0] op, logic [6:0] code,
                                                  logic [10:0] roff);
    console_view_t v;
    int re;
    logic [15:0] a, lim;
    v = '0;
    if (op <= OP_CLEAR) restore_cursor();
    case (op)
      OP_PUT: begin
        chr_mem[cur] = {1'b0, code}; fgc_mem[cur] = fg_col; bgc_mem[cur] = bg_col;
        cur = cur + 16'd1;
        scroll_check();
      end
      OP_NL: begin
        cur = (cur + ROW_CELLS) & ROW_MASK;
        scroll_check();
      end
      OP_LEFT: void'(step_back(16'd1));
      OP_RIGHT: begin
        cur = cur + 16'd1;
        scroll_check();
      end
      OP_UP: void'(step_back(ROW_CELLS));
      OP_DOWN: begin
        cur = cur + ROW_CELLS;
        scroll_check();
      end
      OP_BS: begin
        if (step_back(16'd1)) begin
          re = int'(cur & ROW_MASK) + 63;
          for (int i = int'(cur); i < re; i++) copy_at(16'(i), 16'(i + 1));
          blank_at(16'(re));
        end
      end
      OP_INS: begin
        re = int'(cur & ROW_MASK) + 63;
        for (int i = re; i > int'(cur); i--) copy_at(16'(i), 16'(i - 1));
        blank_at(cur);
      end
      OP_CLEAR: begin
        base = base + WIN_CELLS;
        for (int i = 0; i < 2048; i++) blank_at(base + 16'(i));
        cur = base + bar_limit();
      end
      OP_BAR: begin
        if (bar_on) begin
          bar_on = 0;
        end else begin
          bar_on = 1;
          lim = bar_limit();
          if (16'(cur - base) < lim) begin
            restore_cursor();
            cur = base + lim;
            latch_cursor();
          end
        end
      end
      OP_TICK: begin
        if (blink_cnt == 0) begin
          chr_mem[cur][7] = ~chr_mem[cur][7];
          blink_cnt = blink_per + 8'd255;
          v.blinked = 1;
        end else begin
          blink_cnt = blink_cnt - 8'd1;
        end
      end
      OP_READ: begin
        a = base + 16'(roff);
        v.rchar = chr_mem[a]; v.rfg = fgc_mem[a]; v.rbg = bgc_mem[a];
      end
      default: ;
    endcase
    if (op <= OP_CLEAR) latch_cursor();
    v.cursor = cur;
    v.base = base;
    return v;
  endfunction

  task automatic send_word(logic [3:0] op, logic [6:0] code = 0, logic [10:0] roff = 0);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {2'b0, roff, code, op};
    do @(posedge clk); while (!s_tready);
    expected_views.push_back(console_apply(op, code, roff));
  endtask

  task automatic wait_idle();
    s_tvalid <= 0;
    while (expected_views.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_config(logic [7:0] fg, logic [7:0] bg, logic [6:0] blank,
                            logic [7:0] per, logic [4:0] bar);
    logic [7:0] vals [5];
    vals = '{fg, bg, {1'b0, blank}, per, {3'b0, bar}};
    wait_idle();
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1;
      cfg_addr <= 3'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 0;
    fg_col = fg; bg_col = bg; blank_chr = blank; blink_per = per; bar_rows = bar;
  endtask

  // result checker
  always @(posedge clk) begin
    console_view_t got, want;
    if (rst) begin
      m_tready <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = '{m_tdata[15:0], m_tdata[31:16], m_tdata[39:32], m_tdata[47:40],
                m_tdata[55:48], m_tdata[56]};
        if (expected_views.size() == 0) begin
          $error("unexpected word %h", m_tdata);
          errors++;
        end else begin
          want = expected_views.pop_front();
          if (got.cursor !== want.cursor) begin
            $error("cursor_addr exp %h got %h", want.cursor, got.cursor); errors++;
          end
          if (got.base !== want.base) begin
            $error("window_base exp %h got %h", want.base, got.base); errors++;
          end
          if (got.rchar !== want.rchar) begin
            $error("read_char exp %h got %h", want.rchar, got.rchar); errors++;
          end
          if (got.rfg !== want.rfg) begin
            $error("read_fg exp %h got %h", want.rfg, got.rfg); errors++;
          end
          if (got.rbg !== want.rbg) begin
            $error("read_bg exp %h got %h", want.rbg, got.rbg); errors++;
          end
          if (got.blinked !== want.blinked) begin
            $error("blinked exp %b got %b", want.blinked, got.blinked); errors++;
          end
        end
      end
      m_tready <= ($urandom_range(99) >= dst_idle);
    end
  end

  task automatic test_directed();
    send_word(OP_PUT, 7'h7f);
    send_word(OP_PUT, 7'h00);
    send_word(OP_READ, 0, 11'd576);
    send_word(OP_READ, 0, 11'd2047);
    send_word(OP_TICK);
    send_word(OP_TICK);
    send_word(OP_INS);
    send_word(OP_BS);
    send_word(OP_UP);
    send_word(OP_NL);
    send_word(OP_LEFT);
    send_word(OP_RIGHT);
    send_word(OP_BAR);
    send_word(OP_UP);
    send_word(OP_BAR);
    for (int i = 0; i < 24; i++) send_word(OP_DOWN);
    send_word(4'd12);
    send_word(4'd15);
    send_word(OP_CLEAR);
    send_word(OP_BS);
    send_word(OP_READ, 0, 11'd0);
  endtask

  task automatic test_blink_edges();
    set_config(8'h00, 8'hff, 7'h00, 8'd0, 5'd31);
    send_word(OP_BAR);
    send_word(OP_BAR);
    for (int i = 0; i < 3; i++) send_word(OP_TICK);
    send_word(OP_UP);
    send_word(OP_READ, 0, 11'd1984);
    set_config(8'hff, 8'h00, 7'h7f, 8'd1, 5'd0);
    send_word(OP_CLEAR);
    for (int i = 0; i < 3; i++) send_word(OP_TICK);
    send_word(OP_UP);
    send_word(OP_BS);
    send_word(OP_READ, 0, 11'd0);
  endtask

  task automatic test_random(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(999);
      if (r < 350)      send_word(OP_PUT, 7'($urandom));
      else if (r < 410) send_word(OP_NL);
      else if (r < 470) send_word(OP_LEFT);
      else if (r < 530) send_word(OP_RIGHT);
      else if (r < 590) send_word(OP_UP);
      else if (r < 650) send_word(OP_DOWN);
      else if (r < 710) send_word(OP_BS);
      else if (r < 770) send_word(OP_INS);
      else if (r < 777) send_word(OP_CLEAR);
      else if (r < 800) send_word(OP_BAR);
      else if (r < 890) send_word(OP_TICK);
      else if (r < 990) send_word(OP_READ, 7'($urandom), 11'($urandom));
      else              send_word(4'($urandom_range(15, 12)), 7'($urandom), 11'($urandom));
    end
  endtask

  initial begin
    console_reset();
    repeat (9) @(posedge clk);
    rst <= 0;
    src_idle = 14; dst_idle = 72;
    test_directed();
    test_blink_edges();
    set_config(8'($urandom), 8'($urandom), 7'($urandom), 8'd3, 5'd4);
    test_random(450);
    src_idle = 72; dst_idle = 14;
    set_config(8'($urandom), 8'($urandom), 7'($urandom), 8'd255, 5'd12);
    test_random(450);
    src_idle = 0; dst_idle = 0;
    set_config(RST_FG, RST_BG, RST_BLANK, RST_BLINK, RST_BAR);
    test_random(450);
    wait_idle();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
